// ===== rtl/i2ctrf_pkg.sv =====
`default_nettype none
package i2ctrf_pkg;

	localparam int NUM_TEMP_HUM_DEF = 8;
	localparam int NUM_VOC_DEF      = 4;
	localparam int NUM_CO2_DEF      = 4;
	localparam int HUM_BASE         = 4;
	localparam int REG_SIZE_DEF     = HUM_BASE + 2 * (NUM_TEMP_HUM_DEF + NUM_VOC_DEF + NUM_CO2_DEF);

	localparam int BYTE_W   = 8;
	localparam int BCNT_W   = 6;
	localparam int LV_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 7;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 2;

	localparam logic [2:0] REQ_ADDR  = 3'd0;
	localparam logic [2:0] REQ_RX    = 3'd1;
	localparam logic [2:0] REQ_TX    = 3'd2;
	localparam logic [2:0] REQ_STOP  = 3'd3;
	localparam logic [2:0] REQ_NACK  = 3'd4;
	localparam logic [2:0] REQ_LOCAL = 3'd5;

	localparam logic [2:0] KIND_HUM       = 3'd0;
	localparam logic [2:0] KIND_TEMP      = 3'd1;
	localparam logic [2:0] KIND_VOC       = 3'd2;
	localparam logic [2:0] KIND_CO2       = 3'd3;
	localparam logic [2:0] KIND_TEMP_MASK = 3'd4;
	localparam logic [2:0] KIND_VOC_MASK  = 3'd5;
	localparam logic [2:0] KIND_CO2_MASK  = 3'd6;
	localparam logic [2:0] KIND_CMD       = 3'd7;

	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOC_MASK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CO2_MASK  = 2'd2;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_ADDR  = 2'd1;
	localparam logic [1:0] PH_WRITE = 2'd2;
	localparam logic [1:0] PH_READ  = 2'd3;

	localparam int EN_TEMP_POS = 0;
	localparam int EN_VOC_POS  = 1;
	localparam int EN_CO2_POS  = 2;
	localparam int CMD_POS     = 3;

	localparam logic [7:0]  MASK_RST     = 8'hff;
	localparam logic [7:0]  EN_TEMP_RST  = 8'h7f;
	localparam logic [7:0]  EN_VOC_RST   = 8'h0f;
	localparam logic [7:0]  EN_CO2_RST   = 8'h0f;
	localparam logic [7:0]  CMD_RST      = 8'h00;
	localparam logic [7:0]  HUM_RST      = 8'h32;
	localparam logic [7:0]  TEMP_RST     = 8'h64;
	localparam logic [7:0]  WORD_HI_RST  = 8'h03;
	localparam logic [7:0]  VOC_LO_RST   = 8'h23;
	localparam logic [7:0]  CO2_LO_RST   = 8'h10;
	localparam logic [7:0]  HUM_DEFAULT  = 8'h32;
	localparam logic [7:0]  TEMP_DEFAULT = 8'd70;
	localparam logic [15:0] VOC_DEFAULT  = 16'd800;
	localparam logic [15:0] CO2_DEFAULT  = 16'd900;

	function automatic logic [7:0] reset_byte(input logic [7:0] addr, input int nth,
		input int nv);
		int a;
		int tb;
		int vb;
		int cb;
		logic [7:0] off;
		logic [7:0] res;
		a = int'(addr);
		tb = HUM_BASE + nth;
		vb = tb + nth;
		cb = vb + 2 * nv;
		off = 8'h00;
		if (a == EN_TEMP_POS) begin
			res = EN_TEMP_RST;
		end else if (a == EN_VOC_POS) begin
			res = EN_VOC_RST;
		end else if (a == EN_CO2_POS) begin
			res = EN_CO2_RST;
		end else if (a < HUM_BASE) begin
			res = CMD_RST;
		end else if (a < tb) begin
			res = HUM_RST;
		end else if (a < vb) begin
			res = TEMP_RST;
		end else if (a < cb) begin
			off = 8'(a - vb);
			res = off[0] ? VOC_LO_RST + {1'b0, off[7:1]} : WORD_HI_RST;
		end else begin
			off = 8'(a - cb);
			res = off[0] ? CO2_LO_RST + {1'b0, off[7:1]} : WORD_HI_RST;
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/i2c_target_register_file.sv =====
`default_nettype none
// Pipeline: an accepted transaction is registered into the s1 registers (RAM read, info_s1),
// then into the output registers behind m_tvalid; a stall on m_tready holds both.
// Throughput: one transaction per cycle while the output is not stalled; set by the single
// write and two read ports of the register file memory, accessed once per transaction.
// Reset: arst_n clears the bus phase and byte pointer, sets the masks to 0xff and marks
// every file byte as holding its power-up sensor value; no clearing pass is needed.
module i2c_target_register_file #(
	parameter int NUM_TEMP_HUM = i2ctrf_pkg::NUM_TEMP_HUM_DEF,
	parameter int NUM_VOC      = i2ctrf_pkg::NUM_VOC_DEF,
	parameter int NUM_CO2      = i2ctrf_pkg::NUM_CO2_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// rx_byte [7:0], local_index [15:8]
	input  wire logic [i2ctrf_pkg::S_TDATA_W-1:0]     s_tdata,
	// req_type [2:0], master_reads [3], local_kind [6:4]
	input  wire logic [i2ctrf_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// tx_byte [7:0], byte_count [13:8], local_value [29:14], zero [31:30]
	output logic      [i2ctrf_pkg::M_TDATA_W-1:0]     m_tdata,
	// tx_valid [0], count_loaded [1]
	output logic      [i2ctrf_pkg::M_TUSER_W-1:0]     m_tuser,
	input  wire logic                                 cfg_we,
	input  wire logic [i2ctrf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [i2ctrf_pkg::BYTE_W-1:0]        cfg_wdata
);

	localparam int TEMP_BASE = i2ctrf_pkg::HUM_BASE + NUM_TEMP_HUM;
	localparam int VOC_BASE  = TEMP_BASE + NUM_TEMP_HUM;
	localparam int CO2_BASE  = VOC_BASE + 2 * NUM_VOC;
	localparam int REG_SIZE  = CO2_BASE + 2 * NUM_CO2;
	localparam int PTR_W     = $clog2(REG_SIZE);

	localparam logic [1:0] LV_CONST = 2'd0;
	localparam logic [1:0] LV_BYTE  = 2'd1;
	localparam logic [1:0] LV_WORD  = 2'd2;

	typedef struct packed {
		logic        txv;
		logic        use_tx;
		logic [5:0]  cnt;
		logic        cl;
		logic [1:0]  lv_sel;
		logic [15:0] lv_const;
		logic [7:0]  mask;
	} s1_info_t;

	logic [2:0]       req_type;
	logic             master_reads;
	logic [7:0]       rx_byte;
	logic [2:0]       local_kind;
	logic [7:0]       local_index;

	logic [1:0]       phase_q;
	logic [1:0]       phase_d;
	logic [PTR_W-1:0] ptr_q;
	logic [PTR_W-1:0] ptr_d;
	logic [PTR_W-1:0] ptr_inc;
	logic [REG_SIZE-1:0] vld_q;
	logic [7:0]       th_gate_q;
	logic [7:0]       voc_gate_q;
	logic [7:0]       co2_gate_q;

	logic             accept;
	logic             we;
	logic [PTR_W-1:0] waddr;
	logic [7:0]       wdata;
	logic [PTR_W-1:0] raddr_a;
	logic [PTR_W-1:0] raddr_b;
	logic [7:0]       rdata_a;
	logic [7:0]       rdata_b;
	s1_info_t         info;

	logic             s1_valid_q;
	s1_info_t         info_s1;
	logic             vld_a_s1;
	logic             vld_b_s1;
	logic [7:0]       rst_a_s1;
	logic [7:0]       rst_b_s1;

	logic             out_load;
	logic             out_valid_q;
	logic [7:0]       byte_a;
	logic [7:0]       byte_b;
	logic [7:0]       tx_res;
	logic [15:0]      lv_res;
	logic [7:0]       tx_q;
	logic             txv_q;
	logic [5:0]       cnt_q;
	logic             cl_q;
	logic [15:0]      lv_q;

	assign req_type     = s_tuser[2:0];
	assign master_reads = s_tuser[3];
	assign local_kind   = s_tuser[6:4];
	assign rx_byte      = s_tdata[7:0];
	assign local_index  = s_tdata[15:8];

	assign out_load = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || out_load;
	assign accept   = s_tvalid && s_tready;

	assign ptr_inc = (ptr_q == PTR_W'(REG_SIZE - 1)) ? '0 : ptr_q + 1'b1;

	always_comb begin
		phase_d = phase_q;
		ptr_d = ptr_q;
		we = 1'b0;
		waddr = ptr_q;
		wdata = rx_byte;
		raddr_a = ptr_q;
		raddr_b = ptr_q;
		info = '0;
		info.mask = i2ctrf_pkg::MASK_RST;
		info.lv_sel = LV_CONST;
		case (req_type)
			i2ctrf_pkg::REQ_ADDR: begin
				phase_d = master_reads ? i2ctrf_pkg::PH_READ : i2ctrf_pkg::PH_ADDR;
			end
			i2ctrf_pkg::REQ_RX: begin
				if (phase_q == i2ctrf_pkg::PH_ADDR) begin
					phase_d = i2ctrf_pkg::PH_WRITE;
					info.cl = 1'b1;
					if (rx_byte < 8'(REG_SIZE)) begin
						ptr_d = PTR_W'(rx_byte);
						info.cnt = 6'(8'(REG_SIZE) - rx_byte);
					end
				end else if (phase_q == i2ctrf_pkg::PH_WRITE) begin
					we = 1'b1;
					ptr_d = ptr_inc;
				end
			end
			i2ctrf_pkg::REQ_TX: begin
				if (phase_q == i2ctrf_pkg::PH_READ) begin
					info.txv = 1'b1;
					info.use_tx = 1'b1;
					ptr_d = ptr_inc;
				end
			end
			i2ctrf_pkg::REQ_STOP: begin
				phase_d = i2ctrf_pkg::PH_IDLE;
			end
			i2ctrf_pkg::REQ_LOCAL: begin
				case (local_kind)
					i2ctrf_pkg::KIND_HUM: begin
						if (local_index < 8'(NUM_TEMP_HUM)) begin
							raddr_a = PTR_W'(i2ctrf_pkg::HUM_BASE) + PTR_W'(local_index);
							info.lv_sel = LV_BYTE;
						end else begin
							info.lv_const = {8'h00, i2ctrf_pkg::HUM_DEFAULT};
						end
					end
					i2ctrf_pkg::KIND_TEMP: begin
						if (local_index < 8'(NUM_TEMP_HUM)) begin
							raddr_a = PTR_W'(TEMP_BASE) + PTR_W'(local_index);
							info.lv_sel = LV_BYTE;
						end else begin
							info.lv_const = {8'h00, i2ctrf_pkg::TEMP_DEFAULT};
						end
					end
					i2ctrf_pkg::KIND_VOC: begin
						if (local_index < 8'(NUM_VOC)) begin
							raddr_a = PTR_W'(VOC_BASE) + PTR_W'({local_index, 1'b0});
							raddr_b = raddr_a + 1'b1;
							info.lv_sel = LV_WORD;
						end else begin
							info.lv_const = i2ctrf_pkg::VOC_DEFAULT;
						end
					end
					i2ctrf_pkg::KIND_CO2: begin
						if (local_index < 8'(NUM_CO2)) begin
							raddr_a = PTR_W'(CO2_BASE) + PTR_W'({local_index, 1'b0});
							raddr_b = raddr_a + 1'b1;
							info.lv_sel = LV_WORD;
						end else begin
							info.lv_const = i2ctrf_pkg::CO2_DEFAULT;
						end
					end
					i2ctrf_pkg::KIND_TEMP_MASK: begin
						raddr_a = PTR_W'(i2ctrf_pkg::EN_TEMP_POS);
						info.lv_sel = LV_BYTE;
						info.mask = th_gate_q;
					end
					i2ctrf_pkg::KIND_VOC_MASK: begin
						raddr_a = PTR_W'(i2ctrf_pkg::EN_VOC_POS);
						info.lv_sel = LV_BYTE;
						info.mask = voc_gate_q;
					end
					i2ctrf_pkg::KIND_CO2_MASK: begin
						raddr_a = PTR_W'(i2ctrf_pkg::EN_CO2_POS);
						info.lv_sel = LV_BYTE;
						info.mask = co2_gate_q;
					end
					i2ctrf_pkg::KIND_CMD: begin
						raddr_a = PTR_W'(i2ctrf_pkg::CMD_POS);
						we = 1'b1;
						waddr = PTR_W'(i2ctrf_pkg::CMD_POS);
						wdata = 8'h00;
						info.lv_sel = LV_BYTE;
					end
					default: begin
						info.lv_sel = LV_CONST;
					end
				endcase
			end
			i2ctrf_pkg::REQ_NACK: begin
				phase_d = phase_q;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	i2ctrf_ram #(
		.WIDTH (i2ctrf_pkg::BYTE_W),
		.DEPTH (REG_SIZE)
	) u_ram (
		.clk     (clk),
		.we      (accept && we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (accept),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th_gate_q <= i2ctrf_pkg::MASK_RST;
			voc_gate_q <= i2ctrf_pkg::MASK_RST;
			co2_gate_q <= i2ctrf_pkg::MASK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				i2ctrf_pkg::CFG_TEMP_MASK: th_gate_q <= cfg_wdata;
				i2ctrf_pkg::CFG_VOC_MASK:  voc_gate_q <= cfg_wdata;
				i2ctrf_pkg::CFG_CO2_MASK:  co2_gate_q <= cfg_wdata;
				default: begin
					th_gate_q <= th_gate_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2ctrf_pkg::PH_IDLE;
			ptr_q <= '0;
			vld_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			ptr_q <= ptr_d;
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (out_load) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
			vld_a_s1 <= vld_q[raddr_a];
			vld_b_s1 <= vld_q[raddr_b];
			rst_a_s1 <= i2ctrf_pkg::reset_byte(8'(raddr_a), NUM_TEMP_HUM, NUM_VOC);
			rst_b_s1 <= i2ctrf_pkg::reset_byte(8'(raddr_b), NUM_TEMP_HUM, NUM_VOC);
		end
	end

	always_comb begin
		byte_a = vld_a_s1 ? rdata_a : rst_a_s1;
		byte_b = vld_b_s1 ? rdata_b : rst_b_s1;
		tx_res = info_s1.use_tx ? byte_a : 8'h00;
		case (info_s1.lv_sel)
			LV_BYTE: lv_res = {8'h00, byte_a & info_s1.mask};
			LV_WORD: lv_res = {byte_a, byte_b};
			default: lv_res = info_s1.lv_const;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			tx_q <= tx_res;
			txv_q <= info_s1.txv;
			cnt_q <= info_s1.cnt;
			cl_q <= info_s1.cl;
			lv_q <= lv_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {2'b00, lv_q, cnt_q, tx_q};
	assign m_tuser = {cl_q, txv_q};

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q < PTR_W'(REG_SIZE))
		else $error("byte pointer beyond register file");

	a_cmd_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type == i2ctrf_pkg::REQ_LOCAL && local_kind == i2ctrf_pkg::KIND_CMD
		|=> vld_q[i2ctrf_pkg::CMD_POS])
		else $error("command byte not cleared after local read");

	a_tx_cnt_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("tx_valid and count_loaded both set");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !out_load |=> s1_valid_q && $stable(info_s1))
		else $error("pending transaction lost while output stalled");

endmodule
`default_nettype wire

// ===== rtl/i2ctrf_ram.sv =====
`default_nettype none
module i2ctrf_ram #(
	parameter int WIDTH = i2ctrf_pkg::BYTE_W,
	parameter int DEPTH = i2ctrf_pkg::REG_SIZE_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule
`default_nettype wire

// ===== tb/i2c_target_register_file_tb.sv =====
`default_nettype none
module i2c_target_register_file_tb;
	import i2ctrf_pkg::*;

	localparam int FILE_BYTES  = REG_SIZE_DEF;
	localparam int NUM_TH      = NUM_TEMP_HUM_DEF;
	localparam int NUM_VOC     = NUM_VOC_DEF;
	localparam int NUM_CO2     = NUM_CO2_DEF;
	localparam int TEMP_BASE   = HUM_BASE + NUM_TH;
	localparam int VOC_BASE    = TEMP_BASE + NUM_TH;
	localparam int CO2_BASE    = VOC_BASE + 2 * NUM_VOC;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 610;
	localparam int TAIL_CYCLES = 4;

	localparam logic [2:0] REQ_SPARE_6 = 3'd6;
	localparam logic [2:0] REQ_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [2:0] req_type;
		logic       master_reads;
		logic [7:0] rx_byte;
		logic [2:0] local_kind;
		logic [7:0] local_index;
	} bus_req_t;

	typedef struct packed {
		logic [7:0]  tx_byte;
		logic        tx_valid;
		logic [5:0]  byte_count;
		logic        count_loaded;
		logic [15:0] local_value;
	} bus_res_t;

	typedef struct packed {
		bus_req_t stim;
		logic     typed;
		bus_res_t want;
	} script_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_wdata;

	logic [7:0] file_bytes [FILE_BYTES];
	int         byte_ptr;
	logic [1:0] bus_state;
	logic [7:0] th_gate;
	logic [7:0] voc_gate;
	logic [7:0] co2_gate;

	bus_res_t pending_results [$];
	int       served_items;
	int       mismatches = 0;
	int       cycle_count = 0;
	int       send_idle;
	int       recv_idle;
	int       hold_requests;

	script_row_t script [28] = '{
		'{'{REQ_LOCAL, 1'b0, 8'h00, KIND_CMD,       8'h00}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h0000}},
		'{'{REQ_LOCAL, 1'b1, 8'hff, KIND_HUM,       8'h00}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h0032}},
		'{'{REQ_LOCAL, 1'b0, 8'h00, KIND_TEMP,      8'h07}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h0064}},
		'{'{REQ_LOCAL, 1'b0, 8'h00, KIND_VOC,       8'h03}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h0326}},
		'{'{REQ_LOCAL, 1'b0, 8'h00, KIND_CO2,       8'h00}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h0310}},
		'{'{REQ_LOCAL, 1'b0, 8'h00, KIND_HUM,       8'hff}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h0032}},
		'{'{REQ_LOCAL, 1'b0, 8'h00, KIND_TEMP,      8'h08}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'd70}},
		'{'{REQ_LOCAL, 1'b0, 8'h00, KIND_VOC,       8'h04}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'd800}},
		'{'{REQ_LOCAL, 1'b0, 8'h00, KIND_CO2,       8'hff}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'd900}},
		'{'{REQ_LOCAL, 1'b0, 8'h00, KIND_TEMP_MASK, 8'h00}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h007f}},
		'{'{REQ_LOCAL, 1'b0, 8'h00, KIND_VOC_MASK,  8'h00}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h000f}},
		'{'{REQ_LOCAL, 1'b0, 8'h00, KIND_CO2_MASK,  8'h00}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h000f}},
		'{'{REQ_RX,    1'b1, 8'hff, KIND_CMD,       8'hff}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h0000}},
		'{'{REQ_TX,    1'b1, 8'hff, KIND_CMD,       8'hff}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h0000}},
		'{'{REQ_NACK,  1'b1, 8'hff, KIND_CMD,       8'hff}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h0000}},
		'{'{REQ_SPARE_6, 1'b1, 8'hff, KIND_CMD,     8'hff}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h0000}},
		'{'{REQ_SPARE_7, 1'b1, 8'hff, KIND_CMD,     8'hff}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h0000}},
		'{'{REQ_ADDR,  1'b0, 8'h00, KIND_HUM,       8'h00}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h0000}},
		'{'{REQ_RX,    1'b0, 8'h03, KIND_HUM,       8'h00}, 1'b1, '{8'h00, 1'b0, 6'd33, 1'b1, 16'h0000}},
		'{'{REQ_RX,    1'b0, 8'ha5, KIND_HUM,       8'h00}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h0000}},
		'{'{REQ_RX,    1'b0, 8'h00, KIND_HUM,       8'h00}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h0000}},
		'{'{REQ_ADDR,  1'b0, 8'h00, KIND_HUM,       8'h00}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h0000}},
		'{'{REQ_RX,    1'b0, 8'h24, KIND_HUM,       8'h00}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b1, 16'h0000}},
		'{'{REQ_RX,    1'b0, 8'h5a, KIND_HUM,       8'h00}, 1'b0, '0},
		'{'{REQ_ADDR,  1'b1, 8'h00, KIND_HUM,       8'h00}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h0000}},
		'{'{REQ_TX,    1'b0, 8'h00, KIND_HUM,       8'h00}, 1'b0, '0},
		'{'{REQ_STOP,  1'b0, 8'h00, KIND_HUM,       8'h00}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h0000}},
		'{'{REQ_LOCAL, 1'b0, 8'h00, KIND_CMD,       8'h00}, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 16'h00a5}}
	};

	i2c_target_register_file u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void load_power_up_file();
		for (int i = 0; i < NUM_TH; i++) begin
			file_bytes[HUM_BASE + i]  = HUM_RST;
			file_bytes[TEMP_BASE + i] = TEMP_RST;
		end
		for (int i = 0; i < NUM_VOC; i++) begin
			file_bytes[VOC_BASE + 2 * i]     = WORD_HI_RST;
			file_bytes[VOC_BASE + 2 * i + 1] = VOC_LO_RST + 8'(i);
		end
		for (int i = 0; i < NUM_CO2; i++) begin
			file_bytes[CO2_BASE + 2 * i]     = WORD_HI_RST;
			file_bytes[CO2_BASE + 2 * i + 1] = CO2_LO_RST + 8'(i);
		end
		file_bytes[EN_TEMP_POS] = EN_TEMP_RST;
		file_bytes[EN_VOC_POS]  = EN_VOC_RST;
		file_bytes[EN_CO2_POS]  = EN_CO2_RST;
		file_bytes[CMD_POS]     = CMD_RST;
		byte_ptr  = 0;
		bus_state = PH_IDLE;
		th_gate   = MASK_RST;
		voc_gate  = MASK_RST;
		co2_gate  = MASK_RST;
	endfunction

	function automatic logic [15:0] sensor_value(input logic [2:0] kind, input logic [7:0] idx);
		int         n;
		logic [7:0] cmd;
		n = int'(idx);
		case (kind)
			KIND_HUM:       return n < NUM_TH ?
				{8'h00, file_bytes[HUM_BASE + n]} : {8'h00, HUM_DEFAULT};
			KIND_TEMP:      return n < NUM_TH ?
				{8'h00, file_bytes[TEMP_BASE + n]} : {8'h00, TEMP_DEFAULT};
			KIND_VOC:       return n < NUM_VOC ?
				{file_bytes[VOC_BASE + 2 * n], file_bytes[VOC_BASE + 2 * n + 1]} : VOC_DEFAULT;
			KIND_CO2:       return n < NUM_CO2 ?
				{file_bytes[CO2_BASE + 2 * n], file_bytes[CO2_BASE + 2 * n + 1]} : CO2_DEFAULT;
			KIND_TEMP_MASK: return {8'h00, file_bytes[EN_TEMP_POS] & th_gate};
			KIND_VOC_MASK:  return {8'h00, file_bytes[EN_VOC_POS] & voc_gate};
			KIND_CO2_MASK:  return {8'h00, file_bytes[EN_CO2_POS] & co2_gate};
			default: begin
				cmd = file_bytes[CMD_POS];
				file_bytes[CMD_POS] = 8'h00;
				return {8'h00, cmd};
			end
		endcase
	endfunction

	function automatic bus_res_t serve_request(input bus_req_t r);
		bus_res_t res;
		res = '0;
		case (r.req_type)
			REQ_ADDR: begin
				bus_state = r.master_reads ? PH_READ : PH_ADDR;
			end
			REQ_RX: begin
				if (bus_state == PH_ADDR) begin
					bus_state = PH_WRITE;
					res.count_loaded = 1'b1;
					if (int'(r.rx_byte) < FILE_BYTES) begin
						byte_ptr = int'(r.rx_byte);
						res.byte_count = 6'(FILE_BYTES - byte_ptr);
					end
				end else if (bus_state == PH_WRITE) begin
					file_bytes[byte_ptr] = r.rx_byte;
					byte_ptr = (byte_ptr + 1 >= FILE_BYTES) ? 0 : byte_ptr + 1;
				end
			end
			REQ_TX: begin
				if (bus_state == PH_READ) begin
					res.tx_byte  = file_bytes[byte_ptr];
					res.tx_valid = 1'b1;
					byte_ptr = (byte_ptr + 1 >= FILE_BYTES) ? 0 : byte_ptr + 1;
				end
			end
			REQ_STOP: begin
				bus_state = PH_IDLE;
			end
			REQ_LOCAL: begin
				res.local_value = sensor_value(r.local_kind, r.local_index);
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic offer_request(input bus_req_t r, input logic typed, input bus_res_t want);
		bus_res_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r.local_index, r.rx_byte};
		s_tuser  <= {r.local_kind, r.master_reads, r.req_type};
		do @(posedge clk); while (!s_tready);
		predicted = serve_request(r);
		pending_results.push_back(typed ? want : predicted);
		served_items++;
	endtask

	task automatic stop_offering();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic write_mask(input logic [CFG_IDX_W-1:0] which, input logic [7:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= which;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (which)
			CFG_TEMP_MASK: th_gate  = value;
			CFG_VOC_MASK:  voc_gate = value;
			CFG_CO2_MASK:  co2_gate = value;
			default: ;
		endcase
	endtask

	task automatic await_drain();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic bus_req_t any_request();
		bus_req_t r;
		r.req_type     = 3'($urandom_range(7));
		r.master_reads = 1'($urandom_range(1));
		r.rx_byte      = 8'($urandom_range(255));
		r.local_kind   = 3'($urandom_range(7));
		r.local_index  = 8'($urandom_range(255));
		return r;
	endfunction

	task automatic send_bus(input logic [2:0] code, input logic rd_flag);
		bus_req_t r;
		r = any_request();
		r.req_type     = code;
		r.master_reads = rd_flag;
		offer_request(r, 1'b0, '0);
	endtask

	task automatic send_pointer(input int span);
		bus_req_t r;
		r = any_request();
		r.req_type = REQ_RX;
		r.rx_byte  = 8'($urandom_range(span));
		offer_request(r, 1'b0, '0);
	endtask

	task automatic run_session();
		bus_req_t r;
		int       pick;
		int       n;
		pick = $urandom_range(99);
		if (pick < 35) begin
			send_bus(REQ_ADDR, 1'b0);
			send_pointer(($urandom_range(9) == 0) ? 255 : FILE_BYTES - 1);
			n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
			repeat (n) send_bus(REQ_RX, 1'($urandom_range(1)));
			if ($urandom_range(9) != 0)
				send_bus(($urandom_range(4) == 0) ? REQ_NACK : REQ_STOP, 1'($urandom_range(1)));
		end else if (pick < 65) begin
			if ($urandom_range(1) == 1) begin
				send_bus(REQ_ADDR, 1'b0);
				send_pointer(FILE_BYTES - 1);
			end
			send_bus(REQ_ADDR, 1'b1);
			n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 6);
			repeat (n) send_bus(REQ_TX, 1'($urandom_range(1)));
			send_bus(REQ_NACK, 1'($urandom_range(1)));
			if ($urandom_range(9) != 0)
				send_bus(REQ_STOP, 1'($urandom_range(1)));
		end else if (pick < 85) begin
			repeat ($urandom_range(1, 4)) begin
				r = any_request();
				r.req_type = REQ_LOCAL;
				if ($urandom_range(1) == 1)
					r.local_index = 8'($urandom_range(NUM_TH));
				offer_request(r, 1'b0, '0);
			end
		end else begin
			repeat ($urandom_range(1, 5)) offer_request(any_request(), 1'b0, '0);
		end
	endtask

	task automatic run_phase(input int sender_pct, input int receiver_pct);
		int target;
		send_idle = sender_pct;
		recv_idle = receiver_pct;
		target = served_items + PHASE_ITEMS;
		while (served_items < target) run_session();
		stop_offering();
		await_drain();
	endtask

	initial begin
		int          hold_count;
		int          hold_seen;
		m_tready  = 1'b0;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen++;
				hold_count = 0;
				m_tready <= 1'b0;
				while (hold_count < HOLD_CYCLES) begin
					@(negedge clk);
					hold_count++;
				end
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		bus_res_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected transaction: tdata %0h tuser %0h", m_tdata, m_tuser);
				mismatches++;
			end else begin
				exp_res = pending_results.pop_front();
				if (m_tdata[7:0] !== exp_res.tx_byte) begin
					$error("tx_byte: expected %0h, got %0h", exp_res.tx_byte, m_tdata[7:0]);
					mismatches++;
				end
				if (m_tuser[0] !== exp_res.tx_valid) begin
					$error("tx_valid: expected %0h, got %0h", exp_res.tx_valid, m_tuser[0]);
					mismatches++;
				end
				if (m_tdata[13:8] !== exp_res.byte_count) begin
					$error("byte_count: expected %0d, got %0d", exp_res.byte_count, m_tdata[13:8]);
					mismatches++;
				end
				if (m_tuser[1] !== exp_res.count_loaded) begin
					$error("count_loaded: expected %0h, got %0h", exp_res.count_loaded, m_tuser[1]);
					mismatches++;
				end
				if (m_tdata[29:14] !== exp_res.local_value) begin
					$error("local_value: expected %0h, got %0h", exp_res.local_value,
						m_tdata[29:14]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		served_items  = 0;
		send_idle     = 25;
		recv_idle     = 88;
		hold_requests = 0;
		load_power_up_file();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) offer_request(script[i].stim, script[i].typed, script[i].want);
		stop_offering();
		await_drain();

		write_mask(CFG_TEMP_MASK, 8'h00);
		write_mask(CFG_VOC_MASK, 8'h00);
		write_mask(CFG_CO2_MASK, 8'h00);
		run_phase(25, 88);

		write_mask(CFG_TEMP_MASK, 8'($urandom_range(255)));
		write_mask(CFG_VOC_MASK, 8'($urandom_range(255)));
		write_mask(CFG_CO2_MASK, 8'($urandom_range(255)));
		run_phase(88, 25);

		write_mask(CFG_TEMP_MASK, 8'hff);
		write_mask(CFG_VOC_MASK, 8'hff);
		write_mask(CFG_CO2_MASK, 8'hff);
		// hold the output off so the pipeline fills and backs up the input
		hold_requests = 1;
		run_phase(0, 0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
